FILE: hdl/tkfd_pkg.sv
// Package for the two-kind frame deframer.
// Header and tail byte codes, parse phase codes and count sizing.
// No dependencies.
`default_nettype none
package tkfd_pkg;

  localparam int COUNT_LIMIT = 255;
  localparam int CNT_W = $clog2(COUNT_LIMIT + 1);
  localparam int LEN_W = 8;
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  localparam logic [7:0] HEAD_FIRST = 8'hAA;
  localparam logic [7:0] HEAD_POINT = 8'h55;
  localparam logic [7:0] HEAD_LINE  = 8'h66;
  localparam logic [7:0] TAIL_BYTE  = 8'hBB;

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_POINT  = 2'd2;
  localparam logic [1:0] PH_LINE   = 2'd3;

  localparam logic [LEN_W-1:0] MIN_LEN_RESET = 8'd7;

  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(COUNT_LIMIT);
  localparam logic [CNT_W-1:0] POS_FIRST = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_LAST  = CNT_W'(5);

endpackage
`default_nettype wire

FILE: hdl/two_kind_frame_deframer.sv
// Two-kind frame deframer: header hunt, payload capture, tail check, result register.
// Depends on tkfd_pkg.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | rx_byte
//  out     | out_valid / out_ready| frame_kind, first_value, second_value
//  cfg     | cfg_valid / cfg_ready| cfg_data (min_frame_length)
//
// One byte per cycle while in_ready is high; parser state and any frame result are
// registered at the edge that accepts the byte, so out_valid rises the cycle after
// the tail beat. in_ready drops only while a result waits and out_ready is low.
// cfg_ready is always high. Synchronous active-high reset clears phase,
// count, output valid and sets min_frame_length to 7.
`default_nettype none
module two_kind_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             frame_kind,
  output logic signed [15:0] first_value,
  output logic signed [15:0] second_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [tkfd_pkg::LEN_W-1:0] cfg_data
);
  import tkfd_pkg::*;

  logic [1:0]       phase, phase_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       payload [4];
  logic [7:0]       payload_next [4];
  logic [LEN_W-1:0] min_len;
  logic             res_hit;
  logic             in_acc;
  logic             store_en;
  logic [CNT_W-1:0] stored_count;
  logic [CNT_W-1:0] pos_off;

  assign in_ready  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= MIN_LEN_RESET;
    end else if (cfg_valid) begin
      min_len <= cfg_data;
    end
  end

  // bytes that get counted: first header, valid second header, anything in a frame
  assign store_en = (phase == PH_HUNT)   ? (rx_byte == HEAD_FIRST) :
                    (phase == PH_SECOND) ? (rx_byte == HEAD_POINT || rx_byte == HEAD_LINE) :
                    1'b1;

  // store_byte: counts and captures positions 2..5 unless saturated
  assign pos_off = byte_count - POS_FIRST;
  always_comb begin
    stored_count = byte_count;
    for (int i = 0; i < 4; i++) payload_next[i] = payload[i];
    if (store_en && byte_count < CNT_LIMIT) begin
      if (byte_count >= POS_FIRST && byte_count <= POS_LAST) begin
        payload_next[pos_off[1:0]] = rx_byte;
      end
      stored_count = byte_count + CNT_W'(1);
    end
  end

  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    res_hit         = 1'b0;
    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == HEAD_FIRST) begin
          phase_next      = PH_SECOND;
          byte_count_next = stored_count;
        end
      end
      PH_SECOND: begin
        if (rx_byte == HEAD_POINT || rx_byte == HEAD_LINE) begin
          phase_next      = (rx_byte == HEAD_POINT) ? PH_POINT : PH_LINE;
          byte_count_next = stored_count;
        end else if (rx_byte != HEAD_FIRST) begin
          phase_next      = PH_HUNT;
          byte_count_next = '0;
        end
      end
      default: begin
        byte_count_next = stored_count;
        if (rx_byte == TAIL_BYTE) begin
          res_hit         = CMP_W'(stored_count) >= CMP_W'(min_len);
          phase_next      = PH_HUNT;
          byte_count_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      byte_count <= '0;
    end else if (in_acc) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < 4; i++) payload[i] <= payload_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && res_hit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_hit) begin
      frame_kind   <= (phase == PH_LINE);
      first_value  <= {payload_next[0], payload_next[1]};
      second_value <= {payload_next[2], payload_next[3]};
    end
  end

  a_hunt_zero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HUNT |-> byte_count == '0)
    else $error("count not clear while hunting");

  a_second_one: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SECOND |-> byte_count == CNT_W'(1))
    else $error("count wrong while awaiting second header");

  a_body_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_POINT || phase == PH_LINE) |-> byte_count >= POS_FIRST)
    else $error("count too low inside frame");

  a_tail_hunt: assert property (@(posedge clk) disable iff (rst)
    in_acc && rx_byte == TAIL_BYTE && (phase == PH_POINT || phase == PH_LINE)
    |=> phase == PH_HUNT)
    else $error("tail did not return to hunting");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_acc))
    else $error("result without accepted beat");

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Testbench for two_kind_frame_deframer: directed and random byte streams, with an
// in-bench frame parser predicting every result. Depends on tkfd_pkg and the RTL.
module tb;
  import tkfd_pkg::*;

  localparam int CYCLE_LIMIT   = 100000;
  localparam int SETTLE_CYCLES = 3;
  localparam int TAIL_CYCLES   = 10;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int HOLD_AFTER    = 20;
  localparam int HOLD_CYCLES   = 200;
  localparam int SEG_BYTES     = 120;
  localparam int SEND_IDLE [3] = '{19, 52, 0};
  localparam int RECV_IDLE [3] = '{52, 19, 0};

  localparam logic [7:0] OPENING [28] = '{
    HEAD_FIRST, HEAD_POINT, 8'h00, 8'h00, 8'hFF, 8'hFF, TAIL_BYTE,
    HEAD_FIRST, HEAD_LINE, 8'h80, 8'h00, 8'h7F, 8'hFF, TAIL_BYTE,
    HEAD_FIRST, 8'h12,
    HEAD_FIRST, HEAD_LINE, TAIL_BYTE,
    HEAD_FIRST, HEAD_FIRST, HEAD_FIRST, HEAD_POINT, 8'h01, 8'h02, 8'h03, 8'h04, TAIL_BYTE
  };

  typedef enum logic [1:0] {STEP_BYTE, STEP_CFG, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t kind;
    logic [7:0] data;
  } plan_step_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] first_val;
    logic signed [15:0] second_val;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] rx_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic frame_kind;
  logic signed [15:0] first_value;
  logic signed [15:0] second_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LEN_W-1:0] cfg_data = '0;

  plan_step_t plan_q[$];
  frame_t     frames_due[$];

  logic [1:0]       hunt_phase;
  logic [CNT_W-1:0] frame_count;
  logic [7:0]       frame_bytes [4];
  logic [LEN_W-1:0] min_len;

  int plan_bytes = 0;
  int bytes_sent = 0;
  int idle_stage = 0;
  int settle = 0;
  int frames_open = 0;
  int results_got = 0;
  int hold_left = 0;
  bit held = 1'b0;
  int mismatches = 0;
  int cycles = 0;

  two_kind_frame_deframer uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_kind   (frame_kind),
    .first_value  (first_value),
    .second_value (second_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[two_kind_frame_deframer] ERROR");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b);
    plan_q.push_back('{STEP_BYTE, b});
    plan_bytes++;
  endtask

  task automatic add_setting(input logic [7:0] v);
    plan_q.push_back('{STEP_CFG, v});
  endtask

  // loose: payload may hold the tail code, cutting the frame short
  task automatic add_frame(input logic line, input int len, input bit loose);
    logic [7:0] b;
    add_byte(HEAD_FIRST);
    add_byte(line ? HEAD_LINE : HEAD_POINT);
    for (int i = 3; i < len; i++) begin
      b = 8'($urandom_range(255));
      while (!loose && b == TAIL_BYTE) b = 8'($urandom_range(255));
      add_byte(b);
    end
    add_byte(TAIL_BYTE);
  endtask

  task automatic count_byte(input logic [7:0] b);
    if (frame_count != CNT_LIMIT) begin
      if (frame_count >= POS_FIRST && frame_count <= POS_LAST)
        frame_bytes[2'(frame_count - POS_FIRST)] = b;
      frame_count++;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    frame_t f;
    case (hunt_phase)
      PH_HUNT: begin
        if (b == HEAD_FIRST) begin
          hunt_phase = PH_SECOND;
          count_byte(b);
        end
      end
      PH_SECOND: begin
        if (b == HEAD_POINT || b == HEAD_LINE) begin
          hunt_phase = (b == HEAD_POINT) ? PH_POINT : PH_LINE;
          count_byte(b);
        end else if (b != HEAD_FIRST) begin
          hunt_phase = PH_HUNT;
          frame_count = '0;
        end
      end
      default: begin
        count_byte(b);
        if (b == TAIL_BYTE) begin
          if (frame_count >= min_len) begin
            f.kind = (hunt_phase == PH_LINE);
            f.first_val = {frame_bytes[0], frame_bytes[1]};
            f.second_val = {frame_bytes[2], frame_bytes[3]};
            frames_due.push_back(f);
          end
          hunt_phase = PH_HUNT;
          frame_count = '0;
        end
      end
    endcase
  endtask

  task automatic compare_field(input string field, input logic signed [16:0] want,
                               input logic signed [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // driver
  always @(posedge clk) begin : drive
    logic go_in, go_cfg;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      settle = 0;
    end else begin
      if (in_valid && in_ready) bytes_sent++;
      go_in = in_valid && !in_ready;
      go_cfg = cfg_valid && !cfg_ready;
      if (!go_in && !go_cfg && plan_q.size() != 0) begin
        if (plan_q[0].kind == STEP_BYTE) begin
          settle = 0;
          if ($urandom_range(99) >= SEND_IDLE[idle_stage]) begin
            go_in = 1'b1;
            rx_byte <= plan_q[0].data;
            void'(plan_q.pop_front());
          end
        end else if (frames_open != 0) begin
          settle = 0;
        end else if (settle < SETTLE_CYCLES) begin
          settle++;
        end else begin
          if (plan_q[0].kind == STEP_CFG) begin
            go_cfg = 1'b1;
            cfg_data <= plan_q[0].data;
          end
          settle = 0;
          void'(plan_q.pop_front());
        end
      end
      in_valid <= go_in;
      cfg_valid <= go_cfg;
      idle_stage <= (3 * bytes_sent < plan_bytes) ? 0 :
                    (3 * bytes_sent < 2 * plan_bytes) ? 1 : 2;
    end
  end

  // monitor: check results first, then track config and accepted beats
  always @(posedge clk) begin : watch
    frame_t want;
    if (rst) begin
      out_ready <= 1'b0;
      hunt_phase = PH_HUNT;
      frame_count = '0;
      min_len = MIN_LEN_RESET;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_got++;
        if (frames_due.size() == 0) begin
          $error("unexpected frame: kind %0d first %0d second %0d",
                 frame_kind, first_value, second_value);
          mismatches++;
        end else begin
          want = frames_due.pop_front();
          compare_field("frame_kind", want.kind, frame_kind);
          compare_field("first_value", want.first_val, first_value);
          compare_field("second_value", want.second_val, second_value);
        end
      end
      if (cfg_valid && cfg_ready) min_len = cfg_data;
      if (in_valid && in_ready) deframe_byte(rx_byte);
      frames_open <= frames_due.size();
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held && results_got == HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= RECV_IDLE[idle_stage]);
      end
    end
  end

  initial begin
    int start, made, len, pick;
    int levels [9];
    foreach (OPENING[i]) add_byte(OPENING[i]);
    plan_q.push_back('{STEP_DRAIN, 8'h00});

    levels = '{0, 3, 255, 6, 1, 12, 20, 7, 40};
    levels[6] = $urandom_range(40, 8);
    levels[8] = $urandom_range(60, 2);
    foreach (levels[s]) begin
      add_setting(8'(levels[s]));
      start = plan_bytes;
      made = 0;
      while (plan_bytes - start < SEG_BYTES || made < 3) begin
        pick = $urandom_range(99);
        len = levels[s] + int'($urandom_range(6)) - 3;
        if (len < 3) len = 3 + $urandom_range(5);
        if (pick < 70) begin
          add_frame(1'($urandom_range(1)), len, 1'b0);
          made++;
        end else if (pick < 80) begin
          add_byte(HEAD_FIRST);
          add_byte(8'($urandom_range(255)));
        end else if (pick < 88) begin
          repeat ($urandom_range(3, 1)) add_byte(HEAD_FIRST);
          add_frame(1'($urandom_range(1)), len, 1'b0);
          made++;
        end else if (pick < 94) begin
          add_frame(1'($urandom_range(1)), len, 1'b1);
        end else begin
          repeat ($urandom_range(5, 1)) add_byte(8'($urandom_range(255)));
        end
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (plan_q.size() != 0 || in_valid || cfg_valid);
    for (int i = 0; i < DRAIN_LIMIT && frames_due.size() != 0; i++) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (frames_due.size() != 0) begin
      $error("%0d expected frames never arrived", frames_due.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("[two_kind_frame_deframer] OK");
    else
      $display("[two_kind_frame_deframer] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
hdl/tkfd_pkg.sv
hdl/two_kind_frame_deframer.sv
dv/tb.sv
